FILE: rtl/brc_pkg.sv
// package for the barometer raw compensation block
// shared constants and 32-bit two's-complement helpers; no dependencies
package brc_pkg;

	localparam int unsigned RawW = 20;
	localparam int unsigned DivStages = 32;
	localparam int unsigned AddrW = 5;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_TEMP_CAL  = 2'd0,
		REG_PRESS_LO  = 2'd1,
		REG_PRESS_HI  = 2'd2,
		REG_PRESS_P9  = 2'd3
	} reg_idx_t;

	localparam logic [31:0] FineOffset = 32'd64000;
	localparam logic [31:0] PressBase = 32'd1048576;
	localparam logic [31:0] PressScale = 32'd3125;
	localparam logic [31:0] HalfRange = 32'h8000_0000;
	localparam logic [31:0] P1Offset = 32'd32768;
	localparam logic [31:0] TempRound = 32'd128;

	// divider pipeline word
	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] num;
		logic [31:0] den;
		logic        dbl;
		logic        pv;
		logic [15:0] temp;
	} div_t;

	// arithmetic right shift of a 32-bit pattern
	function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned s);
		return 32'($signed(x) >>> s);
	endfunction

	// sign-extend a 16-bit word
	function automatic logic [31:0] sx16(input logic [15:0] w);
		return {{16{w[15]}}, w};
	endfunction

	// low 32 bits of a product
	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = a * b;
		return p[31:0];
	endfunction

endpackage

FILE: rtl/brc_if.sv
// item channels of the barometer raw compensation block
// depends on brc_pkg
interface brc_in_if import brc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [RawW-1:0] raw_temperature;
	logic [RawW-1:0] pressure_adc;
	modport source (output valid, raw_temperature, pressure_adc, input ready);
	modport sink (input valid, raw_temperature, pressure_adc, output ready);
endinterface

interface brc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] temperature_centi;
	logic [31:0] pressure_pa;
	logic        pressure_valid;
	modport source (output valid, temperature_centi, pressure_pa, pressure_valid, input ready);
	modport sink (input valid, temperature_centi, pressure_pa, pressure_valid, output ready);
endinterface

FILE: rtl/barometer_raw_compensation.sv
// one item per cycle sustained, unless a waiting result holds the pipeline
// the 32-stage restoring divider, one quotient bit a stage, sets the depth
// the whole pipeline holds while a result waits and the sink is not ready
// arst_n clears all valid bits and the calibration registers to zero
// depends on brc_pkg and brc_if
module barometer_raw_compensation import brc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	brc_in_if.sink           in_ch,
	brc_out_if.source        out_ch,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [63:0]      pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	logic [47:0] tcal_q;
	logic [63:0] plo_q, phi_q;
	logic [15:0] p9_q;
	reg_idx_t    idx;

	// configuration registers
	assign idx = reg_idx_t'(paddr[4:3]);
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcal_q <= '0;
			plo_q <= '0;
			phi_q <= '0;
			p9_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_TEMP_CAL: tcal_q <= pwdata[47:0];
				REG_PRESS_LO: plo_q <= pwdata;
				REG_PRESS_HI: phi_q <= pwdata;
				REG_PRESS_P9: p9_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TEMP_CAL: prdata = {16'd0, tcal_q};
			REG_PRESS_LO: prdata = plo_q;
			REG_PRESS_HI: prdata = phi_q;
			REG_PRESS_P9: prdata = {48'd0, p9_q};
			default: prdata = '0;
		endcase
	end

	// calibration words
	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = {16'd0, tcal_q[15:0]};
	assign t2 = sx16(tcal_q[31:16]);
	assign t3 = sx16(tcal_q[47:32]);
	assign p1 = {16'd0, plo_q[15:0]};
	assign p2 = sx16(plo_q[31:16]);
	assign p3 = sx16(plo_q[47:32]);
	assign p4 = sx16(plo_q[63:48]);
	assign p5 = sx16(phi_q[15:0]);
	assign p6 = sx16(phi_q[31:16]);
	assign p7 = sx16(phi_q[47:32]);
	assign p8 = sx16(phi_q[63:48]);
	assign p9 = sx16(p9_q);

	// global advance: the pipeline moves unless a result is stuck
	logic en;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	logic [11:1] v;
	logic [31:0] a_s1, d_s1, m1_s2, m2_s2, v1t_s3, x_s3, fine_s4;
	logic [31:0] tm_s5, v1_s5, qq_s6, pv5_s6, pv2_s6;
	logic [31:0] v2a_s7, w_s7, pv5_s7, pv2_s7, v2_s8, v1b_s8, v1c_s9, pn_s9;
	logic [31:0] v1d_s10, pm_s10;
	logic [15:0] t_s6, t_s7, t_s8, t_s9, t_s10;
	logic [RawW-1:0] ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6, ap_s7, ap_s8;
	logic [31:0] ts5;
	logic [31:0] v2sum, v2_c, v1_c;
	div_t        div11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v <= '0;
		else if (en) v <= {v[10:1], in_ch.valid};
	end

	// temperature scaling ahead of saturation
	assign ts5 = asr(tm_s5, 8);

	// pressure second-order terms
	assign v2sum = v2a_s7 + {pv5_s7[30:0], 1'b0};
	assign v2_c = asr(v2sum, 2) + {p4[15:0], 16'd0};
	assign v1_c = asr(asr(w_s7, 3) + asr(pv2_s7, 1), 18);

	// first eleven stages
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= {15'd0, in_ch.raw_temperature[19:3]} - {t1[30:0], 1'b0};
			d_s1 <= {16'd0, in_ch.raw_temperature[19:4]} - t1;
			ap_s1 <= in_ch.pressure_adc;
			m1_s2 <= mul32(a_s1, t2);
			m2_s2 <= mul32(d_s1, d_s1);
			ap_s2 <= ap_s1;
			v1t_s3 <= asr(m1_s2, 11);
			x_s3 <= mul32(asr(m2_s2, 12), t3);
			ap_s3 <= ap_s2;
			fine_s4 <= v1t_s3 + asr(x_s3, 14);
			ap_s4 <= ap_s3;
			tm_s5 <= mul32(fine_s4, 32'd5) + TempRound;
			v1_s5 <= asr(fine_s4, 1) - FineOffset;
			ap_s5 <= ap_s4;
			if ($signed(ts5) > 32'sd32767) t_s6 <= 16'h7fff;
			else if ($signed(ts5) < -32'sd32768) t_s6 <= 16'h8000;
			else t_s6 <= ts5[15:0];
			qq_s6 <= mul32(asr(v1_s5, 2), asr(v1_s5, 2));
			pv5_s6 <= mul32(v1_s5, p5);
			pv2_s6 <= mul32(p2, v1_s5);
			ap_s6 <= ap_s5;
			v2a_s7 <= mul32(asr(qq_s6, 11), p6);
			w_s7 <= mul32(p3, asr(qq_s6, 13));
			pv5_s7 <= pv5_s6;
			pv2_s7 <= pv2_s6;
			t_s7 <= t_s6;
			ap_s7 <= ap_s6;
			v2_s8 <= v2_c;
			v1b_s8 <= v1_c;
			t_s8 <= t_s7;
			ap_s8 <= ap_s7;
			v1c_s9 <= mul32(P1Offset + v1b_s8, p1);
			pn_s9 <= (PressBase - {12'd0, ap_s8}) - asr(v2_s8, 12);
			t_s9 <= t_s8;
			v1d_s10 <= asr(v1c_s9, 15);
			pm_s10 <= mul32(pn_s9, PressScale);
			t_s10 <= t_s9;
			div11.rem <= '0;
			div11.num <= (pm_s10 < HalfRange) ? {pm_s10[30:0], 1'b0} : pm_s10;
			div11.dbl <= !(pm_s10 < HalfRange);
			div11.den <= v1d_s10;
			div11.pv <= (v1d_s10 != 32'd0);
			div11.temp <= t_s10;
		end
	end

	// restoring divider, one quotient bit a stage
	div_t                dv_s [1:DivStages];
	logic [DivStages:1]  dvv;

	for (genvar k = 0; k < DivStages; k++) begin : g_div
		div_t        cur;
		logic        cur_v;
		logic [32:0] r2;
		logic        ge;
		if (k == 0) begin : g_head
			assign cur = div11;
			assign cur_v = v[11];
		end else begin : g_tail
			assign cur = dv_s[k];
			assign cur_v = dvv[k];
		end
		assign r2 = {cur.rem, cur.num[31]};
		assign ge = r2 >= {1'b0, cur.den};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dvv[k+1] <= 1'b0;
			else if (en) dvv[k+1] <= cur_v;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k+1] <= '{rem: (ge ? 32'(r2 - {1'b0, cur.den}) : r2[31:0]),
					num: {cur.num[30:0], ge}, den: cur.den, dbl: cur.dbl,
					pv: cur.pv, temp: cur.temp};
			end
		end
	end

	// final correction
	logic [31:0] pq;
	logic [31:0] p_sa, qq_sa, pb_sa, p_sb, pb_sb, m9_sb;
	logic [15:0] t_sa, t_sb;
	logic        pv_sa, pv_sb, va, vb;
	logic [31:0] corr;
	assign pq = dv_s[DivStages].dbl ? {dv_s[DivStages].num[30:0], 1'b0}
		: dv_s[DivStages].num;
	assign corr = asr(m9_sb, 12) + asr(pb_sb, 13) + p7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va <= 1'b0;
			vb <= 1'b0;
			out_ch.valid <= 1'b0;
		end else if (en) begin
			va <= dvv[DivStages];
			vb <= va;
			out_ch.valid <= vb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_sa <= pq;
			qq_sa <= mul32({3'd0, pq[31:3]}, {3'd0, pq[31:3]});
			pb_sa <= mul32({2'd0, pq[31:2]}, p8);
			t_sa <= dv_s[DivStages].temp;
			pv_sa <= dv_s[DivStages].pv;
			m9_sb <= mul32(p9, {13'd0, qq_sa[31:13]});
			pb_sb <= pb_sa;
			p_sb <= p_sa;
			t_sb <= t_sa;
			pv_sb <= pv_sa;
			out_ch.temperature_centi <= t_sb;
			out_ch.pressure_pa <= pv_sb ? p_sb + asr(corr, 4) : 32'd0;
			out_ch.pressure_valid <= pv_sb;
		end
	end

endmodule

FILE: rtl/brc_checker.sv
// port-level checks for the barometer raw compensation block
// depends on barometer_raw_compensation; bound to it below
module brc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        pressure_valid,
	input logic [31:0] pressure_pa,
	input logic        pready
);

	// a stalled result stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressure_pa))
		else $error("result dropped under stall");

	// invalid pressure reads zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pressure_valid |-> pressure_pa == 32'd0)
		else $error("pressure nonzero without valid");

	// input taken whenever the sink takes or no result is held
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready || !out_valid |-> in_ready)
		else $error("input stalled with free output");

	a_pready: assert property (@(posedge clk) pready)
		else $error("pready low");

endmodule

bind barometer_raw_compensation brc_checker u_brc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.pressure_valid(out_ch.pressure_valid),
	.pressure_pa(out_ch.pressure_pa),
	.pready(pready)
);

FILE: verif/barometer_raw_compensation_tb.sv
// testbench for barometer_raw_compensation: calibration via the config port, raw pairs in,
// compensated temperature and pressure checked against a local integer predictor
// depends on brc_pkg and the brc_in_if / brc_out_if channel interfaces
module barometer_raw_compensation_tb;
	import brc_pkg::*;

	localparam int unsigned CycleLimit = 600000;
	localparam int unsigned DrainCycles = 60;

	typedef struct packed {
		logic [15:0] temperature_centi;
		logic [31:0] pressure_pa;
		logic        pressure_valid;
	} reading_t;

	logic             clk;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [63:0]      pwdata;
	logic [63:0]      prdata;
	logic             pready;

	brc_in_if  in_ch ();
	brc_out_if out_ch ();

	barometer_raw_compensation DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow calibration registers
	logic [47:0] temp_cal;
	logic [63:0] press_cal_lo;
	logic [63:0] press_cal_hi;
	logic [15:0] press_p9;

	reading_t    pending_readings[$];
	int unsigned error_count;
	int unsigned checked_count;
	int unsigned invalid_count;
	int unsigned saturated_count;
	int unsigned cycle_count;
	int unsigned burst_left;
	int unsigned sink_mode;
	int unsigned sink_hold;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic logic [31:0] shr_signed(input logic [31:0] x, input int unsigned s);
		return $signed(x) >>> s;
	endfunction

	function automatic logic [31:0] ext16(input logic [15:0] w);
		return {{16{w[15]}}, w};
	endfunction

	// integer compensation of one raw pair, all 32-bit wrapping arithmetic
	function automatic reading_t compensate(input logic [19:0] adc_t, input logic [19:0] adc_p);
		logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] at, ap, v1, v2, d, fine, t, p, q, sq;
		reading_t r;
		at = {12'b0, adc_t};
		ap = {12'b0, adc_p};
		t1 = {16'b0, temp_cal[15:0]};
		t2 = ext16(temp_cal[31:16]);
		t3 = ext16(temp_cal[47:32]);
		p1 = {16'b0, press_cal_lo[15:0]};
		p2 = ext16(press_cal_lo[31:16]);
		p3 = ext16(press_cal_lo[47:32]);
		p4 = ext16(press_cal_lo[63:48]);
		p5 = ext16(press_cal_hi[15:0]);
		p6 = ext16(press_cal_hi[31:16]);
		p7 = ext16(press_cal_hi[47:32]);
		p8 = ext16(press_cal_hi[63:48]);
		p9 = ext16(press_p9);

		// temperature and fine value
		v1 = ((at >> 3) - (t1 << 1)) * t2;
		v1 = shr_signed(v1, 11);
		d = (at >> 4) - t1;
		sq = d * d;
		v2 = shr_signed(sq, 12) * t3;
		v2 = shr_signed(v2, 14);
		fine = v1 + v2;
		t = fine * 32'd5 + 32'd128;
		t = shr_signed(t, 8);
		if ($signed(t) > 32767) begin
			r.temperature_centi = 16'h7fff;
		end else if ($signed(t) < -32768) begin
			r.temperature_centi = 16'h8000;
		end else begin
			r.temperature_centi = t[15:0];
		end

		// pressure divisor and offset
		v1 = shr_signed(fine, 1) - 32'd64000;
		q = shr_signed(v1, 2);
		sq = q * q;
		v2 = shr_signed(sq, 11) * p6;
		v2 = v2 + ((v1 * p5) << 1);
		v2 = shr_signed(v2, 2) + (p4 << 16);
		d = p3 * shr_signed(sq, 13);
		t = p2 * v1;
		v1 = shr_signed(shr_signed(d, 3) + shr_signed(t, 1), 18);
		v1 = (32'd32768 + v1) * p1;
		v1 = shr_signed(v1, 15);

		r.pressure_valid = (v1 != 0);
		p = 0;
		if (r.pressure_valid) begin
			p = 32'd1048576 - ap;
			p = (p - shr_signed(v2, 12)) * 32'd3125;
			if (p < 32'h8000_0000) begin
				p = {p[30:0], 1'b0} / v1;
			end else begin
				p = (p / v1) * 32'd2;
			end
			q = p >> 3;
			sq = q * q;
			sq = sq >> 13;
			d = p9 * sq;
			v1 = shr_signed(d, 12);
			t = (p >> 2) * p8;
			v2 = shr_signed(t, 13);
			p = p + shr_signed(v1 + v2 + p7, 4);
		end
		r.pressure_pa = p;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h, expected %0h (time %0t)", field, got, want, $time);
		error_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_readings.size() == 0) begin
				$display("unexpected item from block (time %0t)", $time);
				error_count++;
			end else begin
				want = pending_readings.pop_front();
				checked_count++;
				if (!want.pressure_valid) invalid_count++;
				if (want.temperature_centi == 16'h7fff || want.temperature_centi == 16'h8000)
					saturated_count++;
				if (out_ch.temperature_centi !== want.temperature_centi)
					report_mismatch("temperature_centi", {16'b0, out_ch.temperature_centi},
						{16'b0, want.temperature_centi});
				if (out_ch.pressure_pa !== want.pressure_pa)
					report_mismatch("pressure_pa", out_ch.pressure_pa, want.pressure_pa);
				if (out_ch.pressure_valid !== want.pressure_valid)
					report_mismatch("pressure_valid", {31'b0, out_ch.pressure_valid},
						{31'b0, want.pressure_valid});
			end
		end
	end

	// sink-side ready pattern, with a counted hold-off when requested
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			out_ch.ready <= 1'b0;
		end else begin
			case (sink_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 1) == 1);
				default: out_ch.ready <= ((cycle_count % 5) == 0) || ((cycle_count % 7) == 3);
			endcase
		end
	end

	// register write: setup then access
	task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrW'(idx) << 3;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TEMP_CAL: temp_cal = value[47:0];
			REG_PRESS_LO: press_cal_lo = value;
			REG_PRESS_HI: press_cal_hi = value;
			default: press_p9 = value[15:0];
		endcase
	endtask

	task automatic load_calibration(input logic [47:0] tc, input logic [63:0] lo,
			input logic [63:0] hi, input logic [15:0] nine);
		write_reg(REG_TEMP_CAL, {16'b0, tc});
		write_reg(REG_PRESS_LO, lo);
		write_reg(REG_PRESS_HI, hi);
		write_reg(REG_PRESS_P9, {48'b0, nine});
	endtask

	// send one raw pair, with bursts and gaps on the input side
	task automatic send_pair(input logic [19:0] adc_t, input logic [19:0] adc_p);
		if (burst_left == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		in_ch.valid <= 1'b1;
		in_ch.raw_temperature <= adc_t;
		in_ch.pressure_adc <= adc_p;
		do @(posedge clk); while (!in_ch.ready);
		pending_readings.push_back(compensate(adc_t, adc_p));
		burst_left--;
	endtask

	// stop sending and wait for every result
	task automatic drain;
		in_ch.valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// typical sensor calibration words
	localparam logic [47:0] TypTemp = {16'hfc18, 16'd26435, 16'd27504};
	localparam logic [63:0] TypLo = {16'd2855, 16'd3024, 16'hd643, 16'd36477};
	localparam logic [63:0] TypHi = {16'hc6f8, 16'd15500, 16'hfff9, 16'd140};
	localparam logic [15:0] TypNine = 16'd6000;

	// zero calibration after reset: divisor is zero
	task automatic test_reset_calibration;
		send_pair(20'h00000, 20'h00000);
		send_pair(20'hfffff, 20'hfffff);
		send_pair(20'h7eed0, 20'h65a50);
		drain();
	endtask

	// typical words with field extremes
	task automatic test_typical_directed;
		load_calibration(TypTemp, TypLo, TypHi, TypNine);
		send_pair(20'd519888, 20'd415148);
		send_pair(20'h00000, 20'h00000);
		send_pair(20'hfffff, 20'hfffff);
		send_pair(20'h00000, 20'hfffff);
		send_pair(20'hfffff, 20'h00000);
		send_pair(20'h80000, 20'h80000);
		send_pair(20'h7ffff, 20'h7ffff);
		send_pair(20'd400000, 20'd300000);
		drain();
	endtask

	// extreme calibration words: saturation, wrap and negative divisor
	task automatic test_extreme_calibration;
		load_calibration(48'hffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
			64'hffff_ffff_ffff_ffff, 16'hffff);
		send_pair(20'h00000, 20'h00000);
		send_pair(20'hfffff, 20'hfffff);
		send_pair(20'h55555, 20'haaaaa);
		drain();
		load_calibration({16'h7fff, 16'h7fff, 16'h0000}, {16'h8000, 16'h7fff, 16'h8000, 16'hffff},
			{16'h7fff, 16'h8000, 16'h7fff, 16'h8000}, 16'h8000);
		send_pair(20'hfffff, 20'h00000);
		send_pair(20'h00000, 20'hfffff);
		send_pair(20'haaaaa, 20'h55555);
		drain();
		load_calibration({16'h8000, 16'h8000, 16'hffff}, {16'h7fff, 16'h8000, 16'h7fff, 16'h0001},
			{16'h8000, 16'h7fff, 16'h8000, 16'h7fff}, 16'h7fff);
		send_pair(20'hfffff, 20'hfffff);
		send_pair(20'h00000, 20'h00000);
		send_pair(20'h12345, 20'h6789a);
		drain();
	endtask

	function automatic logic [15:0] near_word(input logic [15:0] base, input int unsigned span);
		return base + 16'($urandom_range(0, 2 * span)) - 16'(span);
	endfunction

	// random phases: mostly realistic calibration, some fully random words
	task automatic test_random_phases;
		logic [47:0] tc;
		logic [63:0] lo, hi;
		logic [15:0] nine;
		int unsigned n;
		for (int ph = 0; ph < 7; ph++) begin
			if (ph % 3 == 2) begin
				tc = 48'({$urandom, $urandom});
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
				nine = 16'($urandom);
			end else begin
				tc = {near_word(16'hfc18, 300), near_word(16'd26435, 800),
					near_word(16'd27504, 1500)};
				lo = {near_word(16'd2855, 500), near_word(16'd3024, 500),
					near_word(16'hd643, 500), near_word(16'd36477, 2000)};
				hi = {near_word(16'hc6f8, 500), near_word(16'd15500, 500),
					near_word(16'hfff9, 20), near_word(16'd140, 50)};
				nine = near_word(16'd6000, 1000);
			end
			load_calibration(tc, lo, hi, nine);
			sink_mode = ph % 3;
			for (n = 0; n < 120; n++) begin
				if ($urandom_range(0, 3) != 0)
					send_pair(20'($urandom_range(380000, 620000)),
						20'($urandom_range(200000, 600000)));
				else
					send_pair(20'($urandom_range(0, 20'hfffff)),
						20'($urandom_range(0, 20'hfffff)));
			end
			drain();
		end
	endtask

	// long sink hold-off while items keep coming, then a full pause
	task automatic test_backpressure;
		load_calibration(TypTemp, TypLo, TypHi, TypNine);
		sink_mode = 0;
		sink_hold = 150;
		for (int n = 0; n < 80; n++)
			send_pair(20'($urandom_range(0, 20'hfffff)), 20'($urandom_range(0, 20'hfffff)));
		drain();
		for (int n = 0; n < 20; n++)
			send_pair(20'($urandom_range(400000, 600000)), 20'($urandom_range(250000, 450000)));
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.raw_temperature = '0;
		in_ch.pressure_adc = '0;
		out_ch.ready = 1'b0;
		temp_cal = '0;
		press_cal_lo = '0;
		press_cal_hi = '0;
		press_p9 = '0;
		error_count = 0;
		checked_count = 0;
		invalid_count = 0;
		saturated_count = 0;
		cycle_count = 0;
		burst_left = 0;
		sink_mode = 0;
		sink_hold = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_calibration();
		test_typical_directed();
		test_extreme_calibration();
		test_random_phases();
		test_backpressure();

		$display("checked %0d results over 13 calibration settings, %0d without valid pressure,",
			checked_count, invalid_count);
		$display("%0d with saturated temperature, under random gaps and sink stalls",
			saturated_count);
		if (error_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
